FILE: src/smxs_pkg.sv
// Shared types and constants for the softmax head action sampler.
`timescale 1ns / 1ps

package smxs_pkg;

  // Sample mode codes; the unused code falls through to softmax sampling
  localparam logic [1:0] MODE_SOFTMAX = 2'd0;
  localparam logic [1:0] MODE_ARGMAX  = 2'd1;
  localparam logic [1:0] MODE_UNIFORM = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_SAMPLE_MODE = 1'b0;
  localparam logic REG_LOGIT_SCALE = 1'b1;

  // Reset values of the registers
  localparam logic [1:0]  SAMPLE_MODE_RESET = MODE_SOFTMAX;
  localparam logic [15:0] LOGIT_SCALE_RESET = 16'd4096;

  // Head sequence: four stored picks, the fifth head closes the action
  localparam int         HEAD_COUNT = 5;
  localparam logic [2:0] HEAD_LAST  = 3'(HEAD_COUNT - 1);

  // log2(e) in Q1.15 and the weight of the largest logit (1.0 in Q1.16)
  localparam logic signed [16:0] LOG2E_Q15  = 17'sd47274;
  localparam logic [16:0]        WEIGHT_ONE = 17'd65536;
  localparam logic [4:0]         SHIFT_MAX  = 5'd17;

  // One policy head as it enters the sampler
  typedef struct packed {
    logic signed [15:0] logit_first;
    logic signed [15:0] logit_second;
    logic signed [15:0] logit_third;
    logic [1:0]         head_width;
    logic [15:0]        random_fraction;
  } head_t;

  // Configuration seen by the sampler
  typedef struct packed {
    logic [1:0]  sample_mode;
    logic [15:0] logit_scale;
  } cfg_t;

  // Pick handed back to the action assembly
  typedef struct packed {
    logic       valid;
    logic [1:0] choice;
  } pick_t;

endpackage

FILE: src/smxs_if.sv
// Valid/ready channel interfaces for policy heads and control actions.
`timescale 1ns / 1ps

interface smxs_head_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] logit_first;
  logic signed [15:0] logit_second;
  logic signed [15:0] logit_third;
  logic [1:0]         head_width;
  logic [15:0]        random_fraction;

  modport source (
    output valid, logit_first, logit_second, logit_third, head_width, random_fraction,
    input  ready
  );
  modport sink (
    input  valid, logit_first, logit_second, logit_third, head_width, random_fraction,
    output ready
  );
endinterface

interface smxs_action_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] throttle;
  logic signed [1:0] steer;
  logic signed [1:0] pitch;
  logic signed [1:0] yaw;
  logic signed [1:0] roll;
  logic              jump;
  logic              boost;
  logic              handbrake;

  modport source (
    output valid, throttle, steer, pitch, yaw, roll, jump, boost, handbrake,
    input  ready
  );
  modport sink (
    input  valid, throttle, steer, pitch, yaw, roll, jump, boost, handbrake,
    output ready
  );
endinterface

FILE: src/smxs_mul.sv
// Shared signed 33x17 multiplier with a registered product.
`timescale 1ns / 1ps

module smxs_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [16:0] b,
  output logic signed [49:0] prod
);

  // Load a new product only when the sequencer issues one; hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 50'(a) * 50'(b);
    end
  end

endmodule

FILE: src/smxs_pick.sv
// Per-head pick sequencer: argmax, uniform draw or scaled softmax sampling.
`timescale 1ns / 1ps

module smxs_pick #(
  parameter int MAX_CHOICES = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  smxs_pkg::head_t item,
  input  smxs_pkg::cfg_t  cfg,
  output logic          idle,
  output smxs_pkg::pick_t result
);

  localparam int         CW   = $clog2(MAX_CHOICES);
  localparam logic [1:0] KMAX = 2'(MAX_CHOICES);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ARGMAX  = 11'b000_0000_0010,
    S_UNI_MUL = 11'b000_0000_0100,
    S_UNI_WR  = 11'b000_0000_1000,
    S_SC_MUL  = 11'b000_0001_0000,
    S_SC_WR   = 11'b000_0010_0000,
    S_WT_SUB  = 11'b000_0100_0000,
    S_WT_MUL  = 11'b000_1000_0000,
    S_WT_WR   = 11'b001_0000_0000,
    S_SUM_MUL = 11'b010_0000_0000,
    S_SCAN    = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic signed [15:0] lg_in [3];
  logic signed [15:0] lg [MAX_CHOICES];
  logic [15:0]        rnd;
  logic [1:0]         k;
  logic [1:0]         k_in;
  logic [CW-1:0]      c;
  logic [CW-1:0]      best;
  logic [CW-1:0]      best_new;
  logic signed [15:0] best_val;
  logic signed [15:0] lg_c;
  logic               c_last;
  logic signed [32:0] sc [MAX_CHOICES];
  logic signed [32:0] sc_new;
  logic signed [32:0] mx;
  logic [31:0]        d;
  logic [16:0]        wt [MAX_CHOICES];
  logic [16:0]        w_base;
  logic [16:0]        w;
  logic               n_big;
  logic [17:0]        sum;
  logic [17:0]        acc;
  logic [17:0]        acc_new;
  logic [17:0]        u;
  logic               hit;
  logic               res_valid;
  logic [1:0]         res_choice;

  logic               mul_en;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod;

  assign lg_in[0] = item.logit_first;
  assign lg_in[1] = item.logit_second;
  assign lg_in[2] = item.logit_third;

  // Clamp the head width to 1..MAX_CHOICES
  always_comb begin
    if (item.head_width == 2'd0) begin
      k_in = 2'd1;
    end else if (item.head_width > KMAX) begin
      k_in = KMAX;
    end else begin
      k_in = item.head_width;
    end
  end

  assign c_last = (2'(c) == (k - 2'd1));

  // Argmax compare: strictly greater keeps the first largest logit
  assign lg_c     = lg[c];
  assign best_new = (lg_c > best_val) ? c : best;

  // Scaled logit from the product register
  assign sc_new = signed'(prod[32:0]);

  // Exponent approximation: t = prod >> 15, n = t >> 20, f = t[19:0]
  assign n_big  = (|prod[47:40]) || (prod[39:35] >= smxs_pkg::SHIFT_MAX);
  assign w_base = smxs_pkg::WEIGHT_ONE - 17'(prod[34:20]);
  assign w      = n_big ? 17'd0 : (w_base >> prod[39:35]);

  // Threshold scan against the running weight sum
  assign u       = prod[33:16];
  assign acc_new = acc + 18'(wt[c]);
  assign hit     = (u <= acc_new);

  // Select multiplier operands for the step in progress
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    if (state == S_UNI_MUL) begin
      mul_en = 1'b1;
      mul_a  = signed'({31'd0, k});
      mul_b  = signed'({1'b0, rnd});
    end else if (state == S_SC_MUL) begin
      mul_en = 1'b1;
      mul_a  = 33'(lg_c);
      mul_b  = signed'({1'b0, cfg.logit_scale});
    end else if (state == S_WT_MUL) begin
      mul_en = 1'b1;
      mul_a  = signed'({1'b0, d});
      mul_b  = smxs_pkg::LOG2E_Q15;
    end else if (state == S_SUM_MUL) begin
      mul_en = 1'b1;
      mul_a  = signed'({15'd0, sum});
      mul_b  = signed'({1'b0, rnd});
    end
  end

  smxs_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Sequence one head through the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            for (int i = 0; i < MAX_CHOICES; i++) begin
              lg[i] <= lg_in[i];
            end
            rnd      <= item.random_fraction;
            k        <= k_in;
            c        <= '0;
            best     <= '0;
            best_val <= lg_in[0];
            sum      <= '0;
            acc      <= '0;
            if (cfg.sample_mode == smxs_pkg::MODE_ARGMAX) begin
              state <= S_ARGMAX;
            end else if (cfg.sample_mode == smxs_pkg::MODE_UNIFORM) begin
              state <= S_UNI_MUL;
            end else begin
              state <= S_SC_MUL;
            end
          end
        end
        S_ARGMAX: begin
          best     <= best_new;
          best_val <= (lg_c > best_val) ? lg_c : best_val;
          c        <= c + CW'(1);
          if (c_last) begin
            res_valid  <= 1'b1;
            res_choice <= 2'(best_new);
            state      <= S_IDLE;
          end
        end
        S_UNI_MUL: begin
          state <= S_UNI_WR;
        end
        S_UNI_WR: begin
          res_valid  <= 1'b1;
          res_choice <= prod[17:16];
          state      <= S_IDLE;
        end
        S_SC_MUL: begin
          state <= S_SC_WR;
        end
        S_SC_WR: begin
          sc[c] <= sc_new;
          if ((c == '0) || (sc_new > mx)) begin
            mx <= sc_new;
          end
          if (c_last) begin
            c     <= '0;
            state <= S_WT_SUB;
          end else begin
            c     <= c + CW'(1);
            state <= S_SC_MUL;
          end
        end
        S_WT_SUB: begin
          d     <= 32'(mx - sc[c]);
          state <= S_WT_MUL;
        end
        S_WT_MUL: begin
          state <= S_WT_WR;
        end
        S_WT_WR: begin
          wt[c] <= w;
          sum   <= sum + 18'(w);
          if (c_last) begin
            c     <= '0;
            state <= S_SUM_MUL;
          end else begin
            c     <= c + CW'(1);
            state <= S_WT_SUB;
          end
        end
        S_SUM_MUL: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          acc <= acc_new;
          if (hit || c_last) begin
            res_valid  <= 1'b1;
            res_choice <= 2'(c);
            state      <= S_IDLE;
          end else begin
            c <= c + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle          = (state == S_IDLE);
  assign result.valid  = res_valid;
  assign result.choice = res_choice;

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("head started while the sampler is busy");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_choice < k))
    else $error("pick outside the head width");

  a_single_pick: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid)
    else $error("more than one pick for one head");
`endif

endmodule

FILE: src/softmax_head_action_sampler_unit.sv
// Top level of the softmax head action sampler: config port, head sequence, action register.
`timescale 1ns / 1ps

// Takes five policy heads in a row on the head channel and, after the fifth,
// delivers one control action beat on the action channel; heads one to four
// produce no beat. Each head runs through a small sequencer around one shared
// signed 33x17 multiplier, and the head channel stays not-ready while a head
// is in work. With k the clamped head width, softmax mode scales each logit
// (multiply, write), forms each exponent weight (subtract, multiply, write),
// multiplies the weight sum by the random fraction, scans up to k weights and
// files the pick; argmax compares the k logits in turn and uniform mode does
// a multiply and a write. The finished action sits in an output register, so
// the next set of heads is taken while it waits; only the fifth head of the
// following set is held off until that beat is taken. The user must write
// registers sample_mode (byte 0) and logit_scale (byte 4) over the APB port
// only while the block is idle; the block itself does not enforce this.
module softmax_head_action_sampler_unit #(
  parameter int MAX_CHOICES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  smxs_head_if.sink            head,
  smxs_action_if.source        action,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [1:0]      sample_mode;
  logic [15:0]     logit_scale;
  logic            cfg_write;
  smxs_pkg::cfg_t  cfg;
  smxs_pkg::head_t item;
  smxs_pkg::pick_t pick;
  logic            pick_idle;
  logic            start;
  logic [2:0]      head_counter;
  logic            counter_last;
  logic [1:0]      picked [smxs_pkg::HEAD_COUNT - 1];
  logic signed [1:0] thr;
  logic signed [1:0] str;
  logic            hb;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= smxs_pkg::SAMPLE_MODE_RESET;
      logit_scale <= smxs_pkg::LOGIT_SCALE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == smxs_pkg::REG_SAMPLE_MODE) begin
        sample_mode <= pwdata[1:0];
      end else begin
        logit_scale <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == smxs_pkg::REG_LOGIT_SCALE) ? {16'd0, logit_scale}
                                                         : {30'd0, sample_mode};

  assign cfg.sample_mode = sample_mode;
  assign cfg.logit_scale = logit_scale;

  // Head beat into the sampler
  assign item.logit_first     = head.logit_first;
  assign item.logit_second    = head.logit_second;
  assign item.logit_third     = head.logit_third;
  assign item.head_width      = head.head_width;
  assign item.random_fraction = head.random_fraction;

  assign counter_last = (head_counter >= smxs_pkg::HEAD_LAST);

  // Hold off while busy, while a pick is being filed, or when the last head
  // would find the action register still full
  assign head.ready = pick_idle && !pick.valid && !(counter_last && action.valid);
  assign start      = head.valid && head.ready;

  smxs_pick #(
    .MAX_CHOICES (MAX_CHOICES)
  ) u_pick (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .cfg    (cfg),
    .idle   (pick_idle),
    .result (pick)
  );

  // Store picks of the first heads
  always_ff @(posedge clk) begin
    if (pick.valid && !counter_last) begin
      picked[head_counter[1:0]] <= pick.choice;
    end
  end

  // Advance the head counter, wrap after the last head
  always_ff @(posedge clk) begin
    if (rst) begin
      head_counter <= '0;
    end else if (pick.valid) begin
      head_counter <= counter_last ? 3'd0 : head_counter + 3'd1;
    end
  end

  // Assemble the action from the stored picks and the last pick
  assign thr = signed'(picked[0] - 2'd1);
  assign str = signed'(picked[1] - 2'd1);
  assign hb  = |pick.choice;

  always_ff @(posedge clk) begin
    if (rst) begin
      action.valid <= 1'b0;
    end else if (pick.valid && counter_last) begin
      action.valid <= 1'b1;
    end else if (action.ready) begin
      action.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pick.valid && counter_last) begin
      action.throttle  <= thr;
      action.steer     <= str;
      action.pitch     <= thr;
      action.yaw       <= hb ? 2'sd0 : str;
      action.roll      <= hb ? str : 2'sd0;
      action.jump      <= |picked[2];
      action.boost     <= |picked[3];
      action.handbrake <= hb;
    end
  end

`ifndef SYNTHESIS
  a_action_slot_free: assert property (@(posedge clk) disable iff (rst)
    (pick.valid && counter_last) |-> !action.valid)
    else $error("action register overwritten before its beat was taken");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    head_counter <= smxs_pkg::HEAD_LAST)
    else $error("head counter beyond the last head");

  a_counter_wrap: assert property (@(posedge clk) disable iff (rst)
    (pick.valid && counter_last) |=> (head_counter == 3'd0) && action.valid)
    else $error("last head did not close the action");
`endif

endmodule
